// ----- rtl/core/tpdq_pkg.sv -----
// shared types and constants for the tree path decomposition query core
`timescale 1ns / 1ps
`default_nettype none

package tpdq_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int VERT_W       = $clog2(MAX_VERTICES);
    localparam int SEND_W       = VERT_W + 1;
    localparam int REQ_W        = 3;

    // light edges climbed per side, capped at ten
    localparam int CLIMB_LIMIT  = (VERT_W > 10) ? 10 : VERT_W;
    localparam int LCA_LIMIT    = 2 * CLIMB_LIMIT;
    localparam int CNT_W        = $clog2(LCA_LIMIT + 1);

    typedef logic [VERT_W-1:0] vertex_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE    = 3'd0,
        REQ_ANCESTOR = 3'd1,
        REQ_PATH     = 3'd2,
        REQ_SUBTREE  = 3'd3,
        REQ_POSITION = 3'd4
    } req_t;

    // one vertex entry as stored in the table memory
    typedef struct packed {
        vertex_t             parent;
        vertex_t             head;
        vertex_t             pre;
        logic [SEND_W-1:0]   send;
    } entry_t;

    typedef struct packed {
        logic    en;
        vertex_t addr;
        entry_t  data;
    } mem_wr_t;

    typedef struct packed {
        logic    en;
        vertex_t addr;
    } mem_rd_t;

    // result command from the sequencer to the output stage
    typedef struct packed {
        logic              push;
        logic              flush;
        logic [SEND_W-1:0] lo;
        vertex_t           hi;
        vertex_t           vert;
        logic              has;
    } res_cmd_t;

    typedef struct packed {
        logic push_ok;
        logic flush_ok;
    } res_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/tpdq_mem.sv -----
// vertex table memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module tpdq_mem (
    input  wire logic              aclk,
    input  wire tpdq_pkg::mem_wr_t wr,
    input  wire tpdq_pkg::mem_rd_t rd,
    output tpdq_pkg::entry_t       rd_data
);

    tpdq_pkg::entry_t mem_reg [tpdq_pkg::MAX_VERTICES];
    tpdq_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg <= mem_reg[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tpdq_out.sv -----
// result hold stage and output register, tags the final result of an item
`timescale 1ns / 1ps
`default_nettype none

module tpdq_out (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire tpdq_pkg::res_cmd_t             cmd,
    output tpdq_pkg::res_stat_t                 stat,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [tpdq_pkg::SEND_W-1:0]         m_seg_low,
    output logic [tpdq_pkg::VERT_W-1:0]         m_seg_high,
    output logic [tpdq_pkg::VERT_W-1:0]         m_result_vertex,
    output logic                                m_has_segment,
    output logic                                m_is_last
);

    logic                        hold_valid_reg, hold_valid_next;
    logic [tpdq_pkg::SEND_W-1:0] hold_lo_reg, hold_lo_next;
    tpdq_pkg::vertex_t           hold_hi_reg, hold_hi_next;

    logic                        m_valid_reg, m_valid_next;
    logic [tpdq_pkg::SEND_W-1:0] lo_reg, lo_next;
    tpdq_pkg::vertex_t           hi_reg, hi_next;
    tpdq_pkg::vertex_t           vert_reg, vert_next;
    logic                        has_reg, has_next;
    logic                        last_reg, last_next;

    logic out_free;

    assign out_free      = !m_valid_reg || m_ready;
    assign stat.push_ok  = !hold_valid_reg || out_free;
    assign stat.flush_ok = out_free;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_lo_next    = hold_lo_reg;
        hold_hi_next    = hold_hi_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        vert_next       = vert_reg;
        has_next        = has_reg;
        last_next       = last_reg;

        if (cmd.push && stat.push_ok) begin
            // the held interval is known not to be last once another arrives
            if (hold_valid_reg) begin
                m_valid_next = 1'b1;
                lo_next      = hold_lo_reg;
                hi_next      = hold_hi_reg;
                vert_next    = '0;
                has_next     = 1'b1;
                last_next    = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_lo_next    = cmd.lo;
            hold_hi_next    = cmd.hi;
        end else if (cmd.flush && out_free) begin
            m_valid_next    = 1'b1;
            last_next       = 1'b1;
            hold_valid_next = 1'b0;
            if (hold_valid_reg) begin
                lo_next   = hold_lo_reg;
                hi_next   = hold_hi_reg;
                vert_next = '0;
                has_next  = 1'b1;
            end else begin
                lo_next   = cmd.lo;
                hi_next   = cmd.hi;
                vert_next = cmd.vert;
                has_next  = cmd.has;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        hold_lo_reg <= hold_lo_next;
        hold_hi_reg <= hold_hi_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        vert_reg    <= vert_next;
        has_reg     <= has_next;
        last_reg    <= last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_seg_low       = lo_reg;
    assign m_seg_high      = hi_reg;
    assign m_result_vertex = vert_reg;
    assign m_has_segment   = has_reg;
    assign m_is_last       = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tpdq_seq.sv -----
// query sequencer: chain jumps through the table memory, at most one read per cycle
`timescale 1ns / 1ps
`default_nettype none

module tpdq_seq (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [tpdq_pkg::REQ_W-1:0]  s_req_type,
    input  wire tpdq_pkg::vertex_t           s_vertex_a,
    input  wire tpdq_pkg::vertex_t           s_vertex_b,
    input  wire logic                        s_include_lca,
    output tpdq_pkg::mem_rd_t                rd,
    input  wire tpdq_pkg::entry_t            rd_data,
    output tpdq_pkg::res_cmd_t               cmd,
    input  wire tpdq_pkg::res_stat_t         stat
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_SINGLE   = 12'b0000_0000_0010,
        S_LCA_B    = 12'b0000_0000_0100,
        S_LCA_U    = 12'b0000_0000_1000,
        S_LCA_TEST = 12'b0000_0001_0000,
        S_LCA_HEAD = 12'b0000_0010_0000,
        S_LCA_V    = 12'b0000_0100_0000,
        S_CL_V     = 12'b0000_1000_0000,
        S_CL_TEST  = 12'b0001_0000_0000,
        S_CL_HEAD  = 12'b0010_0000_0000,
        S_CL_LCA   = 12'b0100_0000_0000,
        S_FINISH   = 12'b1000_0000_0000
    } state_t;

    typedef struct packed {
        tpdq_pkg::vertex_t vert;
        tpdq_pkg::vertex_t head;
        tpdq_pkg::vertex_t pre;
    } node_t;

    state_t state_reg, state_next;
    node_t  v_reg, v_next;
    node_t  u_reg, u_next;
    node_t  w_reg, w_next;
    logic [tpdq_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [tpdq_pkg::REQ_W-1:0] type_reg, type_next;
    tpdq_pkg::vertex_t          a_reg, a_next;
    tpdq_pkg::vertex_t          b_reg, b_next;
    logic                       incl_reg, incl_next;
    logic                       side_reg, side_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        v_next     = v_reg;
        u_next     = u_reg;
        w_next     = w_reg;
        cnt_next   = cnt_reg;
        type_next  = type_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        incl_next  = incl_reg;
        side_next  = side_reg;
        rd         = '0;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    type_next = s_req_type;
                    a_next    = s_vertex_a;
                    b_next    = s_vertex_b;
                    incl_next = s_include_lca;
                    cnt_next  = '0;
                    rd.addr   = s_vertex_a;
                    unique case (s_req_type) inside
                        tpdq_pkg::REQ_ANCESTOR, tpdq_pkg::REQ_PATH: begin
                            rd.en      = 1'b1;
                            state_next = S_LCA_B;
                        end
                        tpdq_pkg::REQ_SUBTREE, tpdq_pkg::REQ_POSITION: begin
                            rd.en      = 1'b1;
                            state_next = S_SINGLE;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SINGLE: begin
                cmd.flush = 1'b1;
                if (type_reg == tpdq_pkg::REQ_SUBTREE) begin
                    cmd.lo  = {1'b0, rd_data.pre};
                    cmd.hi  = tpdq_pkg::VERT_W'(rd_data.send - 1'b1);
                    cmd.has = 1'b1;
                end else begin
                    cmd.vert = rd_data.pre;
                end
                if (stat.flush_ok) begin
                    state_next = S_IDLE;
                end
            end
            S_LCA_B: begin
                v_next     = '{vert: a_reg, head: rd_data.head, pre: rd_data.pre};
                rd.en      = 1'b1;
                rd.addr    = b_reg;
                state_next = S_LCA_U;
            end
            S_LCA_U: begin
                u_next     = '{vert: b_reg, head: rd_data.head, pre: rd_data.pre};
                state_next = S_LCA_TEST;
            end
            S_LCA_TEST: begin
                if (cnt_reg < tpdq_pkg::CNT_W'(tpdq_pkg::LCA_LIMIT)
                    && v_reg.head != u_reg.head) begin
                    // always lift the side that sits deeper in preorder
                    if (v_reg.pre < u_reg.pre) begin
                        v_next = u_reg;
                        u_next = v_reg;
                    end
                    rd.en      = 1'b1;
                    rd.addr    = v_next.head;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_LCA_HEAD;
                end else begin
                    w_next   = (v_reg.pre < u_reg.pre) ? v_reg : u_reg;
                    cnt_next = '0;
                    if (type_reg == tpdq_pkg::REQ_PATH) begin
                        rd.en       = 1'b1;
                        rd.addr     = a_reg;
                        v_next.vert = a_reg;
                        side_next   = 1'b0;
                        state_next  = S_CL_V;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_LCA_HEAD: begin
                rd.en       = 1'b1;
                rd.addr     = rd_data.parent;
                v_next.vert = rd_data.parent;
                state_next  = S_LCA_V;
            end
            S_LCA_V: begin
                v_next.head = rd_data.head;
                v_next.pre  = rd_data.pre;
                state_next  = S_LCA_TEST;
            end
            S_CL_V: begin
                v_next.head = rd_data.head;
                v_next.pre  = rd_data.pre;
                state_next  = S_CL_TEST;
            end
            S_CL_TEST: begin
                if (cnt_reg < tpdq_pkg::CNT_W'(tpdq_pkg::CLIMB_LIMIT)
                    && v_reg.head != w_reg.head) begin
                    rd.en      = 1'b1;
                    rd.addr    = v_reg.head;
                    state_next = S_CL_HEAD;
                end else begin
                    // closing piece of the side, below the ancestor
                    if (w_reg.pre != v_reg.pre) begin
                        cmd.push = 1'b1;
                        cmd.lo   = {1'b0, w_reg.pre} + 1'b1;
                        cmd.hi   = v_reg.pre;
                        cmd.has  = 1'b1;
                    end
                    if (!cmd.push || stat.push_ok) begin
                        state_next = side_reg ? S_FINISH : S_CL_LCA;
                    end
                end
            end
            S_CL_HEAD: begin
                cmd.push = 1'b1;
                cmd.lo   = {1'b0, rd_data.pre};
                cmd.hi   = v_reg.pre;
                cmd.has  = 1'b1;
                if (stat.push_ok) begin
                    rd.en       = 1'b1;
                    rd.addr     = rd_data.parent;
                    v_next.vert = rd_data.parent;
                    cnt_next    = cnt_reg + 1'b1;
                    state_next  = S_CL_V;
                end
            end
            S_CL_LCA: begin
                if (incl_reg) begin
                    cmd.push = 1'b1;
                    cmd.lo   = {1'b0, w_reg.pre};
                    cmd.hi   = w_reg.pre;
                    cmd.has  = 1'b1;
                end
                if (!incl_reg || stat.push_ok) begin
                    rd.en       = 1'b1;
                    rd.addr     = b_reg;
                    v_next.vert = b_reg;
                    side_next   = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_CL_V;
                end
            end
            S_FINISH: begin
                // ancestor answer, or the held last interval, or an empty path
                cmd.flush = 1'b1;
                if (type_reg == tpdq_pkg::REQ_ANCESTOR) begin
                    cmd.vert = w_reg.vert;
                end
                if (stat.flush_ok) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        v_reg    <= v_next;
        u_reg    <= u_next;
        w_reg    <= w_next;
        cnt_reg  <= cnt_next;
        type_reg <= type_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        incl_reg <= incl_next;
        side_reg <= side_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/tree_path_decomposition_query_core.sv -----
// top level of the heavy-light decomposition query core
// a write goes straight into the table; position and subtree read the table once, then go to the output register;
//   ancestor reads both vertices, then each chain jump reads head and parent (at most 20 jumps); path then
//   climbs each side chain by chain, all paced by the single read port of the vertex table
// throughput: one item at a time, next item taken as soon as the last result is staged
// reset: synchronous active-low aresetn clears control only; the table is not
//   cleared and an entry is defined once written
`timescale 1ns / 1ps
`default_nettype none

module tree_path_decomposition_query_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [tpdq_pkg::REQ_W-1:0]   s_req_type,
    input  wire logic [tpdq_pkg::VERT_W-1:0]  s_vertex_a,
    input  wire logic [tpdq_pkg::VERT_W-1:0]  s_vertex_b,
    input  wire logic                         s_include_lca,
    input  wire logic [tpdq_pkg::VERT_W-1:0]  s_entry_parent,
    input  wire logic [tpdq_pkg::VERT_W-1:0]  s_entry_chain_head,
    input  wire logic [tpdq_pkg::VERT_W-1:0]  s_entry_preorder,
    input  wire logic [tpdq_pkg::SEND_W-1:0]  s_entry_subtree_end,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [tpdq_pkg::SEND_W-1:0]       m_seg_low,
    output logic [tpdq_pkg::VERT_W-1:0]       m_seg_high,
    output logic [tpdq_pkg::VERT_W-1:0]       m_result_vertex,
    output logic                              m_has_segment,
    output logic                              m_is_last
);

    tpdq_pkg::mem_wr_t   mem_wr;
    tpdq_pkg::mem_rd_t   mem_rd;
    tpdq_pkg::entry_t    mem_rd_data;
    tpdq_pkg::res_cmd_t  res_cmd;
    tpdq_pkg::res_stat_t res_stat;

    // a write item lands in the table on its own transfer, no sequencer work
    assign mem_wr.en          = s_valid && s_ready && (s_req_type == tpdq_pkg::REQ_WRITE);
    assign mem_wr.addr        = s_vertex_a;
    assign mem_wr.data.parent = s_entry_parent;
    assign mem_wr.data.head   = s_entry_chain_head;
    assign mem_wr.data.pre    = s_entry_preorder;
    assign mem_wr.data.send   = s_entry_subtree_end;

    // vertex table: parent, chain head, preorder and subtree end per vertex
    tpdq_mem u_mem (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (mem_rd_data)
    );

    // sequencer: ancestor search, then climb of each side for path queries; one read for subtree and position
    tpdq_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_vertex_a    (s_vertex_a),
        .s_vertex_b    (s_vertex_b),
        .s_include_lca (s_include_lca),
        .rd            (mem_rd),
        .rd_data       (mem_rd_data),
        .cmd           (res_cmd),
        .stat          (res_stat)
    );

    // one-deep hold so the final interval of a path can be flagged last
    tpdq_out u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (res_cmd),
        .stat            (res_stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_seg_low       (m_seg_low),
        .m_seg_high      (m_seg_high),
        .m_result_vertex (m_result_vertex),
        .m_has_segment   (m_has_segment),
        .m_is_last       (m_is_last)
    );

endmodule

`default_nettype wire
